// File: hw/rtl/cmac_pkg.sv
package cmac_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int BLOCK_BITS  = 8 * BLOCK_BYTES;
    localparam int LAST_ROUND  = 10;

    typedef logic [BLOCK_BITS-1:0] block_t;

    typedef struct packed {
        block_t data;
        logic   last;
    } blk_entry_t;

    typedef enum logic [0:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } cfg_reg_t;

    localparam logic [7:0] SBOX_TABLE [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // byte k of a block sits in bits [127-8k -: 8]
    function automatic logic [7:0] get_byte(input block_t b, input int k);
        get_byte = b[BLOCK_BITS-1-8*k -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic block_t key_next(input block_t rk, input logic [7:0] rcon);
        logic [7:0] k [0:15];
        block_t     r;
        for (int i = 0; i < 16; i++)
        begin
            k[i] = get_byte(rk, i);
        end
        k[0] = k[0] ^ SBOX_TABLE[k[13]] ^ rcon;
        k[1] = k[1] ^ SBOX_TABLE[k[14]];
        k[2] = k[2] ^ SBOX_TABLE[k[15]];
        k[3] = k[3] ^ SBOX_TABLE[k[12]];
        for (int i = 4; i < 16; i++)
        begin
            k[i] = k[i] ^ k[i-4];
        end
        for (int i = 0; i < 16; i++)
        begin
            r[BLOCK_BITS-1-8*i -: 8] = k[i];
        end
        key_next = r;
    endfunction

    // one cipher round; final round skips the column mix
    function automatic block_t aes_round(input block_t st, input block_t rk, input logic fin);
        logic [7:0] t [0:15];
        logic [7:0] a0, a1, a2, a3, s;
        block_t     r;
        for (int c = 0; c < 4; c++)
        begin
            for (int rr = 0; rr < 4; rr++)
            begin
                t[rr+4*c] = SBOX_TABLE[get_byte(st, rr + 4*((c+rr) % 4))];
            end
        end
        if (!fin)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = t[4*c];
                a1 = t[4*c+1];
                a2 = t[4*c+2];
                a3 = t[4*c+3];
                s  = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ s ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ s ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ s ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ s ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            r[BLOCK_BITS-1-8*i -: 8] = t[i];
        end
        aes_round = r ^ rk;
    endfunction

endpackage

// File: hw/rtl/cmac_msg_if.sv
interface cmac_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       last_byte;

    modport source (output valid, output msg_byte, output last_byte, input ready);
    modport sink (input valid, input msg_byte, input last_byte, output ready);
endinterface

// File: hw/rtl/cmac_tag_if.sv
interface cmac_tag_if;
    logic        valid;
    logic        ready;
    logic [63:0] tag_high;
    logic [63:0] tag_low;

    modport source (output valid, output tag_high, output tag_low, input ready);
    modport sink (input valid, input tag_high, input tag_low, output ready);
endinterface

// File: hw/rtl/cmac_cfg_if.sv
interface cmac_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  wr_index;
    logic [63:0] wr_data;

    modport source (output valid, output wr_index, output wr_data, input ready);
    modport sink (input valid, input wr_index, input wr_data, output ready);
endinterface

// File: hw/rtl/cmac_front.sv
module cmac_front
    import cmac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       push,
    output blk_entry_t push_data,
    input  logic       q_full
);
    logic [3:0] pos_reg, pos_next;
    block_t     buf_reg, buf_next;
    block_t     filled;
    logic       take;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        filled = buf_reg;
        filled[BLOCK_BITS-1-8*pos_reg -: 8] = in_byte;
        push           = take && (in_last || (pos_reg == 4'hf));
        push_data.data = filled;
        push_data.last = in_last;
        pos_next = pos_reg;
        buf_next = buf_reg;
        if (take)
        begin
            // a pushed block leaves zeros behind, which pads a short final block
            pos_next = push ? 4'h0 : pos_reg + 4'h1;
            buf_next = push ? '0 : filled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            buf_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            buf_reg <= buf_next;
        end
    end
endmodule

// File: hw/rtl/cmac_queue.sv
module cmac_queue
    import cmac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  blk_entry_t push_data,
    output logic       full,
    input  logic       pop,
    output logic       empty,
    output blk_entry_t pop_data
);
    blk_entry_t mem_reg [0:1];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= 1'b0;
            rp_reg     <= 1'b0;
            cnt_reg    <= 2'd0;
            mem_reg[0] <= '0;
            mem_reg[1] <= '0;
        end
        else
        begin
            if (push)
            begin
                mem_reg[wp_reg] <= push_data;
                wp_reg          <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: hw/rtl/cmac_core.sv
module cmac_core
    import cmac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  block_t      key,
    input  logic        q_empty,
    input  blk_entry_t  q_data,
    output logic        pop,
    output logic        tag_valid,
    input  logic        tag_ready,
    output block_t      tag_data
);
    typedef enum logic [0:0] {IDLE, RUN} state_t;

    state_t     state_reg;
    logic [3:0] round_reg;
    block_t     st_reg, rk_reg, chain_reg, tag_reg;
    logic [7:0] rcon_reg;
    logic       last_reg, tag_valid_reg;
    block_t     rk_n, st_n;
    logic       out_free;

    assign rk_n      = key_next(rk_reg, rcon_reg);
    assign st_n      = aes_round(st_reg, rk_n, round_reg == 4'(LAST_ROUND));
    assign out_free  = !tag_valid_reg || tag_ready;
    assign pop       = (state_reg == IDLE) && !q_empty;
    assign tag_valid = tag_valid_reg;
    assign tag_data  = tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            round_reg     <= '0;
            st_reg        <= '0;
            rk_reg        <= '0;
            chain_reg     <= '0;
            tag_reg       <= '0;
            rcon_reg      <= '0;
            last_reg      <= 1'b0;
            tag_valid_reg <= 1'b0;
        end
        else
        begin
            if (tag_valid_reg && tag_ready)
            begin
                tag_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (!q_empty)
                    begin
                        st_reg    <= q_data.data ^ chain_reg ^ key;
                        rk_reg    <= key;
                        rcon_reg  <= 8'h01;
                        round_reg <= 4'h1;
                        last_reg  <= q_data.last;
                        state_reg <= RUN;
                    end
                end
                RUN:
                begin
                    if (round_reg != 4'(LAST_ROUND))
                    begin
                        st_reg    <= st_n;
                        rk_reg    <= rk_n;
                        rcon_reg  <= xtime(rcon_reg);
                        round_reg <= round_reg + 4'h1;
                    end
                    else if (!last_reg)
                    begin
                        chain_reg <= st_n;
                        state_reg <= IDLE;
                    end
                    else if (out_free)
                    begin
                        // hold the final round until the tag register frees up
                        tag_reg       <= st_n;
                        tag_valid_reg <= 1'b1;
                        chain_reg     <= '0;
                        state_reg     <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end
endmodule

// File: hw/rtl/aes128_cbc_mac_tag_unit.sv
// channel | dir | beat                      | handshake
// msg     | in  | msg_byte[8], last_byte[1] | valid/ready
// tag     | out | tag_high[64], tag_low[64] | valid/ready
// cfg     | in  | wr_index[1], wr_data[64]  | valid/ready, ready always high
//
// Bytes are taken one per cycle while the two-entry block queue has room.
// Each block is loaded and then run through 10 rounds in the round-per-cycle AES unit,
// which keeps pace with full blocks arriving at one byte per cycle.
// Reset clears the key, the partial block, the chaining value and the queue.
// A stalled tag holds the AES unit, which then backs up the queue and msg.
module aes128_cbc_mac_tag_unit
    import cmac_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cmac_msg_if.sink   msg,
    cmac_tag_if.source tag,
    cmac_cfg_if.sink   cfg
);
    logic [63:0] key_high_reg, key_low_reg;
    logic        push, q_full, q_empty, pop;
    blk_entry_t  push_data, pop_data;
    block_t      tag_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.wr_index))
                REG_KEY_HIGH: key_high_reg <= cfg.wr_data;
                REG_KEY_LOW:  key_low_reg  <= cfg.wr_data;
                default:      key_low_reg  <= key_low_reg;
            endcase
        end
    end

    cmac_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (msg.valid),
        .in_ready  (msg.ready),
        .in_byte   (msg.msg_byte),
        .in_last   (msg.last_byte),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    cmac_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .pop_data  (pop_data)
    );

    cmac_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       ({key_high_reg, key_low_reg}),
        .q_empty   (q_empty),
        .q_data    (pop_data),
        .pop       (pop),
        .tag_valid (tag.valid),
        .tag_ready (tag.ready),
        .tag_data  (tag_data)
    );

    assign tag.tag_high = tag_data[127:64];
    assign tag.tag_low  = tag_data[63:0];
endmodule
